>>> hdl/tcba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcba_pkg: shared types and constants
// Sizes, entry layout, result layout and status codes of the texture cache
// bump allocator.
// ----------------------------------------------------------------------------
package tcba_pkg;

  localparam int ENTRIES        = 128;
  localparam int COORD_BITS     = 8;
  localparam int POOL_ADDR_BITS = 20;

  localparam int SLOT_BITS = $clog2(ENTRIES);
  localparam int CNT_BITS  = $clog2(ENTRIES + 1);

  // Request modes
  localparam logic [1:0] MODE_FETCH = 2'd0;
  localparam logic [1:0] MODE_QUERY = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_HIT     = 3'd0;
  localparam logic [2:0] ST_ALLOC   = 3'd1;
  localparam logic [2:0] ST_NO_ROOM = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_BAD     = 3'd4;
  localparam logic [2:0] ST_CLEARED = 3'd5;

  localparam logic [POOL_ADDR_BITS-1:0] POOL_RESET = POOL_ADDR_BITS'(262144);

  // Corner order: u0 v0 u1 v1 u2 v2 u3 v3, u0 in element 0
  typedef logic [7:0][COORD_BITS-1:0] coords_t;

  typedef struct packed {
    logic [15:0]               id;
    coords_t                   coords;
    logic [POOL_ADDR_BITS-1:0] offset;
  } entry_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [6:0]  slot;
    logic [18:0] mem_offset;
    logic [8:0]  padded_width;
    logic [7:0]  rows;
  } result_t;

endpackage

>>> hdl/tcba_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcba_if: request and result channels
// Valid/ready channels; a transfer happens on a clock edge with both high.
// ----------------------------------------------------------------------------
interface tcba_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [15:0] texture_id;
  logic [7:0]  u0;
  logic [7:0]  v0;
  logic [7:0]  u1;
  logic [7:0]  v1;
  logic [7:0]  u2;
  logic [7:0]  v2;
  logic [7:0]  u3;
  logic [7:0]  v3;

  modport source (output valid, mode, texture_id, u0, v0, u1, v1, u2, v2, u3, v3,
                  input ready);
  modport sink   (input valid, mode, texture_id, u0, v0, u1, v1, u2, v2, u3, v3,
                  output ready);
endinterface

interface tcba_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [6:0]  slot;
  logic [18:0] mem_offset;
  logic [8:0]  padded_width;
  logic [7:0]  rows;

  modport source (output valid, status, slot, mem_offset, padded_width, rows,
                  input ready);
  modport sink   (input valid, status, slot, mem_offset, padded_width, rows,
                  output ready);
endinterface

>>> hdl/tcba_entry_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcba_entry_ram: entry table storage
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcba_entry_ram (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [tcba_pkg::SLOT_BITS-1:0] wr_addr,
  input  tcba_pkg::entry_t               wr_data,
  input  logic [tcba_pkg::SLOT_BITS-1:0] rd_addr,
  output tcba_pkg::entry_t               rd_data
);

  tcba_pkg::entry_t mem [tcba_pkg::ENTRIES];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

>>> hdl/texture_cache_bump_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texture_cache_bump_allocator_core: texture cache with bump allocator
// Looks up texture id + UV corners in an entry table, allocates pool space
// on a miss, answers queries and clears the pool.
// ----------------------------------------------------------------------------
// One request is handled at a time. Clear and bad-coordinate requests go
// from S_CHECK straight to S_EMIT. Lookups walk the entry memory one entry
// per cycle through its single read port, up to the entry count; a hit ends
// the walk early. The result sits in an output register, so the next
// request is taken while a result waits. No clearing pass is needed after
// reset: only entries below the entry count are ever read.
module texture_cache_bump_allocator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [19:0] cfg_wdata,
  tcba_in_if.sink     in_ch,
  tcba_out_if.source  out_ch
);

  typedef enum logic [2:0] {S_IDLE, S_CHECK, S_SCAN, S_DECIDE, S_EMIT} state_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [15:0]       id;
    tcba_pkg::coords_t coords;
  } req_t;

  localparam int PB = tcba_pkg::POOL_ADDR_BITS;
  localparam int SB = tcba_pkg::SLOT_BITS;
  localparam int CB = tcba_pkg::CNT_BITS;
  localparam int WB = tcba_pkg::COORD_BITS + 1;

  state_t            state_r, state_nxt;
  req_t              req_r, req_nxt;
  logic [WB-1:0]     w_r, w_nxt;
  logic [7:0]        h_r, h_nxt;
  logic [18:0]       size_r, size_nxt;
  logic [CB-1:0]     rd_idx_r, rd_idx_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic [SB-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic [CB-1:0]     cnt_r, cnt_nxt;
  logic [PB-1:0]     used_r, used_nxt;
  logic [PB-1:0]     pool_r, pool_nxt;
  tcba_pkg::result_t res_r, res_nxt;
  tcba_pkg::result_t out_r, out_nxt;
  logic              out_vld_r, out_vld_nxt;

  tcba_pkg::entry_t  wr_data;
  tcba_pkg::entry_t  rd_data;
  logic              wr_en;

  logic              out_free;
  logic              issue;
  logic              hit;
  logic              bad;
  logic [WB-1:0]     orig_w;
  logic [WB:0]       w_sum;
  logic [16:0]       prod;
  logic [18:0]       size_raw;
  logic [PB:0]       need;

  // Entry table
  tcba_entry_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cnt_r[SB-1:0]),
    .wr_data (wr_data),
    .rd_addr (rd_idx_r[SB-1:0]),
    .rd_data (rd_data)
  );

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_vld_r;
  assign out_ch.status       = out_r.status;
  assign out_ch.slot         = out_r.slot;
  assign out_ch.mem_offset   = out_r.mem_offset;
  assign out_ch.padded_width = out_r.padded_width;
  assign out_ch.rows         = out_r.rows;

  assign out_free = !out_vld_r || out_ch.ready;

  // Geometry of the held request
  assign bad    = ({1'b0, req_r.coords[2]} + WB'(1)) < {1'b0, req_r.coords[0]} ||
                  (req_r.coords[7] < req_r.coords[1]);
  assign orig_w = {1'b0, req_r.coords[2]} + WB'(1) - {1'b0, req_r.coords[0]};
  assign w_sum  = {1'b0, orig_w} + (WB + 1)'(7);

  // Allocation size in bytes, 8-byte aligned
  assign prod     = 17'(w_r * h_r);
  assign size_raw = {1'b0, prod, 1'b0} + 19'd7;

  // Scan pipeline: read issue and compare of the previous read
  assign issue = (rd_idx_r < cnt_r);
  assign hit   = cmp_vld_r && (rd_data.id == req_r.id) &&
                 (rd_data.coords == req_r.coords);

  assign need = {1'b0, used_r} + (PB + 1)'(size_r);

  assign wr_data.id     = req_r.id;
  assign wr_data.coords = req_r.coords;
  assign wr_data.offset = used_r;

  // Next-state logic
  always_comb begin
    state_nxt   = state_r;
    req_nxt     = req_r;
    w_nxt       = w_r;
    h_nxt       = h_r;
    size_nxt    = size_r;
    rd_idx_nxt  = rd_idx_r;
    cmp_vld_nxt = 1'b0;
    cmp_idx_nxt = cmp_idx_r;
    cnt_nxt     = cnt_r;
    used_nxt    = used_r;
    pool_nxt    = cfg_we ? cfg_wdata[PB-1:0] : pool_r;
    res_nxt     = res_r;
    out_nxt     = out_r;
    out_vld_nxt = out_vld_r && !out_ch.ready;
    wr_en       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          req_nxt.mode      = in_ch.mode;
          req_nxt.id        = in_ch.texture_id;
          req_nxt.coords[0] = in_ch.u0[tcba_pkg::COORD_BITS-1:0];
          req_nxt.coords[1] = in_ch.v0[tcba_pkg::COORD_BITS-1:0];
          req_nxt.coords[2] = in_ch.u1[tcba_pkg::COORD_BITS-1:0];
          req_nxt.coords[3] = in_ch.v1[tcba_pkg::COORD_BITS-1:0];
          req_nxt.coords[4] = in_ch.u2[tcba_pkg::COORD_BITS-1:0];
          req_nxt.coords[5] = in_ch.v2[tcba_pkg::COORD_BITS-1:0];
          req_nxt.coords[6] = in_ch.u3[tcba_pkg::COORD_BITS-1:0];
          req_nxt.coords[7] = in_ch.v3[tcba_pkg::COORD_BITS-1:0];
          state_nxt         = S_CHECK;
        end
      end

      S_CHECK: begin
        w_nxt       = {w_sum[WB-1:3], 3'b000};
        h_nxt       = 8'(req_r.coords[7] - req_r.coords[1]);
        rd_idx_nxt  = '0;
        res_nxt     = '0;
        state_nxt   = S_EMIT;
        if (req_r.mode == tcba_pkg::MODE_CLEAR) begin
          cnt_nxt        = '0;
          used_nxt       = '0;
          res_nxt.status = tcba_pkg::ST_CLEARED;
        end else if (bad) begin
          res_nxt.status = tcba_pkg::ST_BAD;
        end else begin
          state_nxt = S_SCAN;
        end
      end

      S_SCAN: begin
        size_nxt = {size_raw[18:3], 3'b000};
        if (hit) begin
          res_nxt.status       = tcba_pkg::ST_HIT;
          res_nxt.slot         = 7'(cmp_idx_r);
          res_nxt.mem_offset   = 19'(rd_data.offset);
          res_nxt.padded_width = 9'(w_r);
          res_nxt.rows         = h_r;
          state_nxt            = S_EMIT;
        end else if (issue) begin
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = rd_idx_r[SB-1:0];
          rd_idx_nxt  = rd_idx_r + CB'(1);
        end else if (!cmp_vld_r) begin
          state_nxt = S_DECIDE;
        end
      end

      S_DECIDE: begin
        res_nxt.slot         = '0;
        res_nxt.mem_offset   = '0;
        res_nxt.padded_width = 9'(w_r);
        res_nxt.rows         = h_r;
        state_nxt            = S_EMIT;
        if (cnt_r == CB'(tcba_pkg::ENTRIES)) begin
          res_nxt.status = tcba_pkg::ST_FULL;
        end else if (need >= {1'b0, pool_r}) begin
          res_nxt.status = tcba_pkg::ST_NO_ROOM;
        end else begin
          res_nxt.status     = tcba_pkg::ST_ALLOC;
          res_nxt.slot       = 7'(cnt_r);
          res_nxt.mem_offset = 19'(used_r);
          if (req_r.mode == tcba_pkg::MODE_FETCH) begin
            wr_en    = 1'b1;
            used_nxt = need[PB-1:0];
            cnt_nxt  = cnt_r + CB'(1);
          end
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_nxt     = res_r;
          out_vld_nxt = 1'b1;
          state_nxt   = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cmp_vld_r <= 1'b0;
      cnt_r     <= '0;
      used_r    <= '0;
      pool_r    <= tcba_pkg::POOL_RESET;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      cnt_r     <= cnt_nxt;
      used_r    <= used_nxt;
      pool_r    <= pool_nxt;
      out_vld_r <= out_vld_nxt;
    end
    req_r     <= req_nxt;
    w_r       <= w_nxt;
    h_r       <= h_nxt;
    size_r    <= size_nxt;
    rd_idx_r  <= rd_idx_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

`ifndef ASSERT_OFF
  // The entry count never passes the table size
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CB'(tcba_pkg::ENTRIES))
    else $error("entry count above table size");

  // A table write only happens with room left in the table
  a_wr_room: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (cnt_r < CB'(tcba_pkg::ENTRIES)))
    else $error("table write with full table");

  // A compare only looks at filled entries
  a_cmp_filled: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && cmp_vld_r) |-> ({1'b0, cmp_idx_r} < cnt_r))
    else $error("compare of an unfilled entry");

  // A finished result reaches the output register once the output is free
  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && out_free) |=> (out_vld_r && state_r == S_IDLE))
    else $error("result not loaded into output register");
`endif

endmodule
